// ===== rtl/hotp_pkg.sv =====
// ----------------------------------------------------------------------------
// HOTP package
// Shared constants and helper functions for the one-time code generator.
// ----------------------------------------------------------------------------
package hotp_pkg;

  localparam int MaxKeyBytes  = 24;
  localparam int KeyLenWidth  = 5;
  localparam int CodeWidth    = 20;
  localparam int FactorWidth  = 64;
  localparam logic [31:0] CodeModulus = 32'd1000000;
  localparam logic [31:0] WindowMask  = 32'h7FFFFFFF;
  localparam logic [3:0]  NibbleMask  = 4'hF;

  // configuration register indexes
  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyMid  = 2'd1;
  localparam logic [1:0] RegKeyLow  = 2'd2;
  localparam logic [1:0] RegKeyLen  = 2'd3;

  localparam logic [159:0] ShaInit =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  // round constant by round number
  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20)      round_k = 32'h5A827999;
    else if (r < 7'd40) round_k = 32'h6ED9EBA1;
    else if (r < 7'd60) round_k = 32'h8F1BBCDC;
    else                round_k = 32'hCA62C1D6;
  endfunction

  // round function by round number
  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20)      round_f = (b & c) | (~b & d);
    else if (r < 7'd40) round_f = b ^ c ^ d;
    else if (r < 7'd60) round_f = (b & c) | (b & d) | (c & d);
    else                round_f = b ^ c ^ d;
  endfunction

endpackage

// ===== rtl/hotp_sha1_round.sv =====
// ----------------------------------------------------------------------------
// HOTP SHA-1 round unit
// One compression engine: loads a 512-bit block, runs one round per cycle
// for 80 rounds with a 16-word schedule window, then adds into the chain.
// ----------------------------------------------------------------------------
module hotp_sha1_round (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [159:0] chain_in,
  input  logic [511:0] block,
  output logic         done,
  output logic [159:0] chain_out
);
  import hotp_pkg::*;

  logic [31:0]  a, b, c, d, e;
  logic [511:0] sched;
  logic [6:0]   round;
  logic         busy;
  logic [159:0] chain;

  logic [31:0] w_cur, w_new, t_sum, x;

  assign w_cur = sched[511:480];
  assign x     = sched[447:416] ^ sched[255:224] ^ sched[95:64] ^ sched[511:480];
  assign w_new = {x[30:0], x[31]};
  assign t_sum = {a[26:0], a[31:27]} + round_f(round, b, c, d) + e + round_k(round) + w_cur;

  // step one round per cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      round <= '0;
      chain <= chain_in;
      {a, b, c, d, e} <= chain_in;
      sched <= block;
    end else if (busy) begin
      a <= t_sum;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
      sched <= {sched[479:0], w_new};
      round <= round + 7'd1;
      if (round == 7'd79) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign chain_out = {chain[159:128] + a, chain[127:96] + b, chain[95:64] + c,
                      chain[63:32] + d, chain[31:0] + e};
endmodule

// ===== rtl/hotp_mod.sv =====
// ----------------------------------------------------------------------------
// HOTP modulo unit
// Reduces a 32-bit value modulo one million by reciprocal multiplication:
// estimate the quotient, subtract its multiple, then fold once.
// ----------------------------------------------------------------------------
module hotp_mod (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [31:0]                    value,
  output logic                           done,
  output logic [hotp_pkg::CodeWidth-1:0] rem
);
  import hotp_pkg::*;

  // floor(2^32 / 10^6); the estimate is low by at most one
  localparam logic [12:0] ModRecip = 13'd4294;

  logic [31:0]          v;
  logic [12:0]          q;
  logic [20:0]          r;
  logic [CodeWidth-1:0] acc;
  logic [2:0]           stage;

  logic [44:0] prod;
  logic [31:0] qm;
  logic [31:0] diff;
  logic [20:0] r_fold;

  assign prod   = 45'(v) * 45'(ModRecip);
  assign qm     = 32'(q) * CodeModulus;
  assign diff   = v - qm;
  assign r_fold = (r >= 21'(CodeModulus)) ? (r - 21'(CodeModulus)) : r;

  // capture, estimate quotient, take remainder, fold once
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      done  <= stage[2];
    end
    if (start) v <= value;
    q   <= prod[44:32];
    r   <= diff[20:0];
    acc <= r_fold[CodeWidth-1:0];
  end

  assign rem = acc;
endmodule

// ===== rtl/hotp_code_generator_core.sv =====
// ----------------------------------------------------------------------------
// HOTP code generator core
// HMAC-SHA1 six-digit one-time code over a 64-bit moving factor.
// ----------------------------------------------------------------------------
// Usage: write the key words and key length on the cfg channel while idle;
// cfg_ready is low while an item is in flight.
// Each moving_factor item yields one otp_code item.
// Flow: four SHA-1 compressions, each a start, 80 rounds in the single
// round unit and a handoff, then truncation and the modulo unit before
// out_valid rises.
// One item at a time: in_ready stays low from acceptance until the
// result has been taken.
// The result is held on out_valid/otp_code while the receiver stalls.
// Reset clears the sequencer and restores the key to zero with length 20.
// ----------------------------------------------------------------------------
module hotp_code_generator_core #(
  parameter int MAX_KEY_BYTES = hotp_pkg::MaxKeyBytes
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [63:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hotp_pkg::FactorWidth-1:0] moving_factor,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hotp_pkg::CodeWidth-1:0]   otp_code
);
  import hotp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_IPAD  = 7'b0000010,
    S_IMSG  = 7'b0000100,
    S_OPAD  = 7'b0001000,
    S_OMSG  = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [63:0] key_high, key_mid, key_low, factor;
  logic [KeyLenWidth-1:0] key_len;
  logic [159:0] chain, inner;
  logic         sha_start, sha_done, mod_start, mod_done;
  logic [159:0] sha_out;
  logic [511:0] block;
  logic [511:0] key_block;
  logic [31:0]  window;
  logic [CodeWidth-1:0] rem;
  logic [6:0]   len_eff;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_mid  <= '0;
      key_low  <= '0;
      key_len  <= KeyLenWidth'(20);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegKeyHigh: key_high <= cfg_data;
        RegKeyMid:  key_mid  <= cfg_data;
        RegKeyLow:  key_low  <= cfg_data;
        RegKeyLen:  key_len  <= cfg_data[KeyLenWidth-1:0];
        default:    ;
      endcase
    end
  end

  // effective key length, clamped
  always_comb begin
    len_eff = {2'd0, key_len};
    if (len_eff < 7'd1) len_eff = 7'd1;
    if (len_eff > 7'(MAX_KEY_BYTES)) len_eff = 7'(MAX_KEY_BYTES);
  end

  // key block with unused bytes zeroed, then padded
  always_comb begin
    logic [191:0] kw;
    kw = {key_high, key_mid, key_low};
    key_block = '0;
    for (int i = 0; i < 24; i++) begin
      if (7'(i) < len_eff) key_block[511-8*i -: 8] = kw[191-8*i -: 8];
    end
  end

  // select the block for the current compression
  always_comb begin
    case (state)
      S_IPAD:  block = key_block ^ {64{8'h36}};
      S_OPAD:  block = key_block ^ {64{8'h5C}};
      S_IMSG:  block = {factor, 8'h80, 376'd0, 64'd576};
      S_OMSG:  block = {inner, 8'h80, 280'd0, 64'd672};
      default: block = '0;
    endcase
  end

  // dynamic truncation window
  always_comb begin
    logic [3:0] off;
    off = sha_out[3:0] & NibbleMask;
    window = sha_out[159 - 8*off -: 32] & WindowMask;
  end

  hotp_sha1_round u_round (
    .clk(clk), .rst(rst), .start(sha_start), .chain_in(chain), .block(block),
    .done(sha_done), .chain_out(sha_out)
  );

  hotp_mod u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .value(window),
    .done(mod_done), .rem(rem)
  );

  logic started;

  assign sha_start = !started &&
    (state == S_IPAD || state == S_IMSG || state == S_OPAD || state == S_OMSG);
  assign mod_start = (state == S_OMSG) && sha_done;

  // sequence the four compressions and the reduction
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      started <= 1'b0;
    end else begin
      if (sha_start) started <= 1'b1;
      case (state)
        S_IDLE: if (in_valid) begin
          factor  <= moving_factor;
          chain   <= ShaInit;
          started <= 1'b0;
          state   <= S_IPAD;
        end
        S_IPAD: if (sha_done) begin
          chain <= sha_out; started <= 1'b0; state <= S_IMSG;
        end
        S_IMSG: if (sha_done) begin
          inner <= sha_out; chain <= ShaInit; started <= 1'b0; state <= S_OPAD;
        end
        S_OPAD: if (sha_done) begin
          chain <= sha_out; started <= 1'b0; state <= S_OMSG;
        end
        S_OMSG: if (sha_done) state <= S_MOD;
        S_MOD: if (mod_done) begin
          otp_code <= rem; state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
